FILE: rtl/core/htlm_pkg.sv
// ----------------------------------------------------------------------------
// htlm_pkg
// Types and constants shared by the heap trend and leak monitor.
// ----------------------------------------------------------------------------
package htlm_pkg;

   localparam int DIV_BITS = 64;

   localparam logic [1:0] CSR_LEAK_RUN_LENGTH = 2'd0;
   localparam logic [1:0] CSR_RECENT_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_ANCIENT_PERIOD  = 2'd2;
   localparam logic [1:0] CSR_SETTLE_COUNT    = 2'd3;

   localparam logic [7:0]  RESET_LEAK_RUN_LENGTH = 8'd5;
   localparam logic [7:0]  RESET_RECENT_PERIOD   = 8'd10;
   localparam logic [11:0] RESET_ANCIENT_PERIOD  = 12'd120;
   localparam logic [7:0]  RESET_SETTLE_COUNT    = 8'd3;

   localparam logic REPORT_STATS = 1'b0;
   localparam logic REPORT_LEAK  = 1'b1;

   // datapath select for the shared divider
   localparam logic [1:0] DIV_RECENT  = 2'd0;
   localparam logic [1:0] DIV_ANCIENT = 2'd1;
   localparam logic [1:0] DIV_TREND   = 2'd2;

   typedef struct packed {
      logic        is_full_compaction;
      logic [31:0] heap_usage;
      logic [31:0] now_seconds;
      logic        stats_wanted;
   } req_type;

   typedef struct packed {
      logic               report_kind;
      logic               last_of_run;
      logic [31:0]        full_count;
      logic [31:0]        incremental_count;
      logic [31:0]        compaction_count;
      logic signed [31:0] heap_trend;
      logic [31:0]        avg_base;
      logic [31:0]        last_base;
      logic [31:0]        min_base;
      logic [31:0]        max_base;
      logic [31:0]        leak_start_time;
      logic [31:0]        leak_growth;
   } rsp_type;

   typedef struct packed {
      logic       take_item;    // latch input and do counters and run tracking
      logic       div_start;
      logic [1:0] div_sel;
      logic       div_commit;   // store quotient of selected division, or usage while warm
      logic       finish;       // min/max update
      logic       load_leak;
      logic       load_stats;
   } cmd_type;

   typedef struct packed {
      logic is_full;
      logic leak_hit;
      logic want;
      logic warm;           // averages copy usage
      logic trend_zero;     // ancient average is zero
      logic div_done;
   } sts_type;

endpackage

FILE: rtl/core/heap_trend_leak_monitor.sv
// ----------------------------------------------------------------------------
// heap_trend_leak_monitor
// Heap usage trend and leak run monitor for collection events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | htlm_pkg::req_type
//  rsp     | out       | rsp_valid/stall   | htlm_pkg::rsp_type
//  csr     | in        | csr_valid/ready   | index 2 bits, data 12 bits
//
//  a compaction runs the recent and ancient average divisions, skipped while
//  the averages copy usage, then the trend division when stats are wanted and
//  the ancient average is nonzero, in sequence on the one shared divider
//  reset is synchronous and restores the register defaults
//  a stalled result holds the sequencer before the next result is loaded
// ----------------------------------------------------------------------------
module heap_trend_leak_monitor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  htlm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output htlm_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [11:0]        csr_data
);

   htlm_pkg::cmd_type cmd;
   htlm_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   htlm_control u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   htlm_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_item (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_data)
   );

endmodule

FILE: rtl/core/htlm_divider.sv
// ----------------------------------------------------------------------------
// htlm_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htlm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [htlm_pkg::DIV_BITS-1:0]  dividend,
   input  logic [htlm_pkg::DIV_BITS-1:0]  divisor,
   output logic                           done,
   output logic [htlm_pkg::DIV_BITS-1:0]  quotient
);

   localparam int CW = $clog2(htlm_pkg::DIV_BITS + 1);

   logic [htlm_pkg::DIV_BITS-1:0] quo_ff, quo_in, den_ff, den_in;
   logic [htlm_pkg::DIV_BITS:0]   rem_ff, rem_in, trial;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[htlm_pkg::DIV_BITS-1:0], quo_ff[htlm_pkg::DIV_BITS-1]};
      if (start) begin
         quo_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(htlm_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[htlm_pkg::DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[htlm_pkg::DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/htlm_datapath.sv
// ----------------------------------------------------------------------------
// htlm_datapath
// Monitor state, averages, trend and result formation.
// ----------------------------------------------------------------------------
module htlm_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [11:0]             csr_data,
   input  htlm_pkg::req_type       req_item,
   input  htlm_pkg::cmd_type       cmd,
   output htlm_pkg::sts_type       sts,
   output htlm_pkg::rsp_type       rsp_item
);

   logic [7:0]  run_len_ff, rec_per_ff, settle_ff;
   logic [11:0] anc_per_ff;
   logic [31:0] full_ff, incr_ff, comp_ff, prev_ff, rec_ff, anc_ff, low_ff, high_ff;
   logic [31:0] start_time_ff, start_usage_ff;
   logic [7:0]  run_ff;
   logic [31:0] usage_ff;
   logic        full_ev_ff, want_ff, leak_ff;
   logic        trend_neg_ff;
   htlm_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] run_inc, comp_inc, r_eff, d_eff, absdiff;
   logic [htlm_pkg::DIV_BITS-1:0] dvd, dvs, quo;
   logic        div_done;
   logic [31:0] trend_val;

   assign run_inc  = {24'd0, run_ff + 8'd1};
   assign comp_inc = comp_ff;
   assign r_eff = (rec_per_ff > 8'd1) ? {24'd0, rec_per_ff} : 32'd1;
   always_comb begin
      d_eff = ({20'd0, anc_per_ff} < comp_ff) ? {20'd0, anc_per_ff} : comp_ff;
      if (d_eff == 32'd0) d_eff = 32'd1;
   end
   assign absdiff = (rec_ff >= anc_ff) ? rec_ff - anc_ff : anc_ff - rec_ff;

   always_comb begin
      case (cmd.div_sel)
         htlm_pkg::DIV_RECENT: begin
            dvd = {32'd0, rec_ff} * {32'd0, r_eff - 32'd1} + {32'd0, usage_ff};
            dvs = {32'd0, r_eff};
         end
         htlm_pkg::DIV_ANCIENT: begin
            dvd = {32'd0, anc_ff} * {32'd0, d_eff - 32'd1} + {32'd0, usage_ff};
            dvs = {32'd0, d_eff};
         end
         default: begin
            dvd = ({32'd0, absdiff} * 64'd2000) + {32'd0, anc_ff};
            dvs = {31'd0, anc_ff, 1'b0};
         end
      endcase
   end

   htlm_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dvd),
      .divisor (dvs),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      if (quo > 64'h7FFF_FFFF) trend_val = 32'h7FFF_FFFF;
      else trend_val = quo[31:0];
      if (trend_neg_ff) trend_val = 32'd0 - quo[31:0];
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_leak) begin
         rsp_in = '0;
         rsp_in.report_kind     = htlm_pkg::REPORT_LEAK;
         rsp_in.last_of_run     = !want_ff;
         rsp_in.leak_start_time = start_time_ff;
         rsp_in.leak_growth     = usage_ff - start_usage_ff;
      end else if (cmd.load_stats) begin
         rsp_in = '0;
         rsp_in.report_kind       = htlm_pkg::REPORT_STATS;
         rsp_in.last_of_run       = 1'b1;
         rsp_in.full_count        = full_ff;
         rsp_in.incremental_count = incr_ff;
         rsp_in.compaction_count  = comp_ff;
         rsp_in.heap_trend        = (anc_ff == 32'd0) ? 32'sd0 : signed'(trend_val);
         rsp_in.avg_base          = rec_ff;
         rsp_in.last_base         = prev_ff;
         rsp_in.min_base          = low_ff;
         rsp_in.max_base          = high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff <= htlm_pkg::RESET_LEAK_RUN_LENGTH;
         rec_per_ff <= htlm_pkg::RESET_RECENT_PERIOD;
         anc_per_ff <= htlm_pkg::RESET_ANCIENT_PERIOD;
         settle_ff  <= htlm_pkg::RESET_SETTLE_COUNT;
         full_ff <= '0; incr_ff <= '0; comp_ff <= '0; prev_ff <= '0;
         rec_ff <= '0; anc_ff <= '0; low_ff <= '0; high_ff <= '0;
         run_ff <= '0; start_time_ff <= '0; start_usage_ff <= '0;
         leak_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               htlm_pkg::CSR_LEAK_RUN_LENGTH: run_len_ff <= csr_data[7:0];
               htlm_pkg::CSR_RECENT_PERIOD:   rec_per_ff <= csr_data[7:0];
               htlm_pkg::CSR_ANCIENT_PERIOD:  anc_per_ff <= csr_data;
               htlm_pkg::CSR_SETTLE_COUNT:    settle_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         if (cmd.take_item) begin
            leak_ff <= 1'b0;
            if (!req_item.is_full_compaction) begin
               incr_ff <= incr_ff + 32'd1;
            end else begin
               full_ff <= full_ff + 32'd1;
               if (prev_ff < req_item.heap_usage) begin
                  if (run_ff == 8'd0) begin
                     start_time_ff  <= req_item.now_seconds;
                     start_usage_ff <= req_item.heap_usage;
                  end
                  if (run_inc[7:0] >= run_len_ff) begin
                     run_ff  <= 8'd0;
                     leak_ff <= 1'b1;
                  end else begin
                     run_ff <= run_inc[7:0];
                  end
               end else begin
                  run_ff <= 8'd0;
               end
               prev_ff <= req_item.heap_usage;
               comp_ff <= comp_inc + 32'd1;
            end
         end
         if (cmd.div_commit) begin
            if (comp_ff < {24'd0, rec_per_ff}) begin
               rec_ff <= usage_ff;
               anc_ff <= usage_ff;
            end else if (cmd.div_sel == htlm_pkg::DIV_RECENT) begin
               rec_ff <= quo[31:0];
            end else begin
               anc_ff <= quo[31:0];
            end
         end
         if (cmd.finish && comp_ff >= {24'd0, settle_ff}) begin
            if (low_ff == 32'd0 || low_ff > usage_ff) low_ff <= usage_ff;
            if (high_ff == 32'd0 || high_ff < usage_ff) high_ff <= usage_ff;
         end
      end
      if (cmd.take_item) begin
         usage_ff   <= req_item.heap_usage;
         full_ev_ff <= req_item.is_full_compaction;
         want_ff    <= req_item.stats_wanted;
      end
      if (cmd.div_start) trend_neg_ff <= rec_ff < anc_ff;
      rsp_ff <= rsp_in;
   end

   assign sts.is_full    = full_ev_ff;
   assign sts.leak_hit   = leak_ff;
   assign sts.want       = want_ff;
   assign sts.warm       = comp_ff < {24'd0, rec_per_ff};
   assign sts.trend_zero = (anc_ff == 32'd0);
   assign sts.div_done   = div_done;
   assign rsp_item       = rsp_ff;

endmodule

FILE: rtl/core/htlm_control.sv
// ----------------------------------------------------------------------------
// htlm_control
// Sequencer for one event: counters, two average divisions or warm-up copy, trend, reports.
// ----------------------------------------------------------------------------
module htlm_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  htlm_pkg::sts_type   sts,
   output htlm_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_DIV_R   = 4'd2;
   localparam logic [3:0] S_WAIT_R  = 4'd3;
   localparam logic [3:0] S_DIV_A   = 4'd4;
   localparam logic [3:0] S_WAIT_A  = 4'd5;
   localparam logic [3:0] S_MINMAX  = 4'd6;
   localparam logic [3:0] S_LEAK    = 4'd7;
   localparam logic [3:0] S_LEAK_W  = 4'd8;
   localparam logic [3:0] S_DIV_T   = 4'd9;
   localparam logic [3:0] S_WAIT_T  = 4'd10;
   localparam logic [3:0] S_STATS_W = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && rsp_stall;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = sts.is_full ? S_DIV_R : S_IDLE;
         S_DIV_R: begin
            cmd.div_sel = htlm_pkg::DIV_RECENT;
            if (sts.warm) begin
               cmd.div_commit = 1'b1;
               state_in = S_MINMAX;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_WAIT_R;
            end
         end
         S_WAIT_R: begin
            cmd.div_sel = htlm_pkg::DIV_RECENT;
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in = S_DIV_A;
            end
         end
         S_DIV_A: begin
            cmd.div_sel = htlm_pkg::DIV_ANCIENT;
            cmd.div_start = 1'b1;
            state_in = S_WAIT_A;
         end
         S_WAIT_A: begin
            cmd.div_sel = htlm_pkg::DIV_ANCIENT;
            if (sts.div_done) begin
               cmd.div_commit = 1'b1;
               state_in = S_MINMAX;
            end
         end
         S_MINMAX: begin
            cmd.finish = 1'b1;
            state_in = S_LEAK;
         end
         S_LEAK: begin
            if (sts.leak_hit) begin
               if (!valid_ff || !rsp_stall) begin
                  cmd.load_leak = 1'b1;
                  valid_in = 1'b1;
                  state_in = S_LEAK_W;
               end
            end else begin
               state_in = S_LEAK_W;
            end
         end
         S_LEAK_W: begin
            cmd.div_sel = htlm_pkg::DIV_TREND;
            if (!sts.want) begin
               state_in = S_IDLE;
            end else if (sts.trend_zero) begin
               state_in = S_STATS_W;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_WAIT_T;
            end
         end
         S_WAIT_T: begin
            cmd.div_sel = htlm_pkg::DIV_TREND;
            if (sts.div_done) state_in = S_STATS_W;
         end
         S_STATS_W: begin
            cmd.div_sel = htlm_pkg::DIV_TREND;
            if (!valid_ff || !rsp_stall) begin
               cmd.load_stats = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_leak || cmd.load_stats) |-> (!valid_ff || !rsp_stall))
      else $error("result overwritten");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |=> (state_ff == S_CHECK))
      else $error("bad take");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_leak && cmd.load_stats))
      else $error("double load");

endmodule
